// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros that are used by the RTL. They compile to nothing when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every clock edge, during reset too.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted minimum priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SERVE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [COUNT_W-1:0]      t_count;

    typedef struct packed {
        logic        command;
        logic signed [31:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               served_valid;
        logic signed [31:0] served_key;
        logic [4:0]         entry_count;
        logic signed [31:0] head_key;
    } t_out_item;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_in;   // insert: cells at or after the slot move up
        logic shift_out;  // serve: each cell takes its upper neighbour, the last keeps its key
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ---------------------------------------------------------------------------
// spq_cell
// One entry of the sorted chain: holds a key, compares it with the key being
// inserted and takes its new value from itself, one of its neighbours or the new key.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire                      i_occupied,
    input  wire spq_pkg::t_key       i_new_key,
    input  wire spq_pkg::t_key       i_prev_key,
    input  wire                      i_prev_less,
    input  wire spq_pkg::t_key       i_next_key,
    output spq_pkg::t_key            o_key,
    output spq_pkg::t_key            o_next_key,
    output logic                     o_less
);
    import spq_pkg::*;

    t_key r_key;
    t_key n_key;

    // Keys are ascending, so the cells that hold a smaller key form a prefix.
    assign o_less = i_occupied && (r_key < i_new_key);

    always_comb begin
        n_key = r_key;
        if (i_ctrl.shift_out) begin
            n_key = i_next_key;
        end else if (i_ctrl.shift_in && !o_less) begin
            n_key = i_prev_less ? i_new_key : i_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key <= n_key;
        end
    end

    assign o_key      = r_key;
    assign o_next_key = n_key;

endmodule

`default_nettype wire

// ===== rtl/sorted_min_priority_queue.sv =====
// ---------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded minimum priority queue of signed keys, held in ascending order in
// a chain of cells that all compare and shift in the same cycle.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel carries a command (insert or serve) and a key. Every
//   input beat gives exactly one result beat with a status, the served key,
//   the entry count and the head key after the command.
//   The result is registered: it is loaded into the output register at the
//   edge that takes the input beat.
//   Throughput is one beat per cycle while the receiver does not stall, as
//   every cell of the chain compares and shifts at once.
//   A serve on an empty queue reports an empty status; an insert into a full
//   queue reports a full status and drops the key.
//   Reset empties the queue and clears the output valid; the key cells are
//   not cleared, as entries beyond the count are never read.
//   While the receiver stalls a waiting result, the input is stalled too; a
//   new beat is taken in the same cycle as the waiting result leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_min_priority_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire spq_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output spq_pkg::t_out_item      o_out_data,
    input  wire                     i_out_stall
);
    import spq_pkg::*;

    `include "assert_macros.svh"

    t_count     r_count;
    t_count     n_count;
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  n_out_data;

    logic       w_accept;
    logic       w_insert_ok;
    logic       w_serve_ok;
    t_cell_ctrl w_ctrl;

    t_key       w_key      [QUEUE_DEPTH];
    t_key       w_next_key [QUEUE_DEPTH];
    logic       w_less     [QUEUE_DEPTH+1];
    logic       w_occupied [QUEUE_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_insert_ok = (i_in_data.command == CMD_INSERT) &&
                         (r_count < t_count'(QUEUE_DEPTH));
    assign w_serve_ok  = (i_in_data.command == CMD_SERVE) &&
                         (r_count != '0);

    assign w_ctrl.shift_in  = w_insert_ok;
    assign w_ctrl.shift_out = w_serve_ok;

    // The first cell sees a smaller key in front of it, so it takes the new
    // key whenever its own key is not smaller.
    assign w_less[0] = 1'b1;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        t_key w_prev;
        t_key w_next;

        assign w_occupied[i] = t_count'(i) < r_count;

        if (i == 0) begin : g_first
            assign w_prev = i_in_data.key_value;
        end else begin : g_mid
            assign w_prev = w_key[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_key[i];
        end else begin : g_up
            assign w_next = w_key[i+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_en        (w_accept),
            .i_ctrl      (w_ctrl),
            .i_occupied  (w_occupied[i]),
            .i_new_key   (i_in_data.key_value),
            .i_prev_key  (w_prev),
            .i_prev_less (w_less[i]),
            .i_next_key  (w_next),
            .o_key       (w_key[i]),
            .o_next_key  (w_next_key[i]),
            .o_less      (w_less[i+1])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_insert_ok) begin
            n_count = r_count + t_count'(1);
        end else if (w_serve_ok) begin
            n_count = r_count - t_count'(1);
        end

        n_out_data              = '0;
        n_out_data.entry_count  = 5'(n_count);
        n_out_data.head_key     = (n_count == '0) ? '0 : w_next_key[0];
        n_out_data.served_valid = w_serve_ok;
        n_out_data.served_key   = w_serve_ok ? w_key[0] : '0;
        unique case (i_in_data.command)
            CMD_INSERT: n_out_data.status = w_insert_ok ? ST_OK : ST_FULL;
            CMD_SERVE:  n_out_data.status = w_serve_ok ? ST_OK : ST_EMPTY;
            default:    n_out_data.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SPQ_ASSERT(a_count_bound, r_count <= t_count'(QUEUE_DEPTH), "count above depth")
    `SPQ_ASSERT(a_head_sorted, w_occupied[1] |-> (w_key[0] <= w_key[1]), "head out of order")
    `SPQ_ASSERT(a_serve_count, (w_accept && w_serve_ok) |=> (r_count == $past(r_count) - t_count'(1)), "serve count")
    `SPQ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_out_valid, "valid after reset")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted minimum priority queue testbench
// Drives random and directed insert and serve commands into the queue and
// checks every result beat against a behavioural copy of the sorted store.
// Both sides idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_REPORTS     = 20;

    // Keeps its own sorted copy of the queue and the results it owes.
    class queue_scoreboard;
        t_key      model_keys[QUEUE_DEPTH];
        int        held;
        t_out_item expected_results[$];
        int        mismatches;
        int        results_seen;
        int        full_drops;
        int        empty_serves;
        int        keys_served;
        int        commands_seen;

        function new();
            held          = 0;
            mismatches    = 0;
            results_seen  = 0;
            full_drops    = 0;
            empty_serves  = 0;
            keys_served   = 0;
            commands_seen = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_command(t_in_item item);
            t_out_item res;
            int        slot;
            int        i;
            res = '0;
            commands_seen++;
            if (item.command == CMD_INSERT) begin
                if (held >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                    full_drops++;
                end else begin
                    slot = 0;
                    while (slot < held &&
                           $signed(model_keys[slot]) < $signed(item.key_value))
                        slot++;
                    for (i = held; i > slot; i--)
                        model_keys[i] = model_keys[i-1];
                    model_keys[slot] = item.key_value;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                    empty_serves++;
                end else begin
                    res.served_valid = 1'b1;
                    res.served_key   = model_keys[0];
                    for (i = 1; i < held; i++)
                        model_keys[i-1] = model_keys[i];
                    held--;
                    keys_served++;
                end
            end
            res.entry_count = 5'(held);
            res.head_key    = (held > 0) ? model_keys[0] : '0;
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result %0d %s: got %0h, expected %0h",
                         $realtime, results_seen, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                report_mismatch("beat with nothing expected", '0, '0);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.served_valid !== want.served_valid)
                    report_mismatch("served_valid", 32'(got.served_valid),
                                    32'(want.served_valid));
                if (got.served_key !== want.served_key)
                    report_mismatch("served_key", got.served_key, want.served_key);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(got.entry_count),
                                    32'(want.entry_count));
                if (got.head_key !== want.head_key)
                    report_mismatch("head_key", got.head_key, want.head_key);
            end
            results_seen++;
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_data;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall;

    queue_scoreboard sb;
    bit              hold_request = 1'b0;
    bit              no_gaps      = 1'b0;
    int              idle_cycles  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_min_priority_queue u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    function automatic t_key pick_key();
        int v;
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3, 4: begin
                // A narrow range gives plenty of equal keys.
                v = int'($urandom_range(8)) - 4;
                return t_key'(v);
            end
            default: return t_key'($urandom());
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(30, 8);
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_command(input logic cmd, input t_key key);
        int unsigned gap;
        t_in_item    item;
        gap            = pick_gap();
        item.command   = cmd;
        item.key_value = key;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        sb.note_command(item);
    endtask

    // Result monitor: values read here are those from before the edge.
    always @(posedge clk) begin
        if (rst_n && sb != null && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    always @(posedge clk) begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $realtime, idle_cycles);
            $display("** sorted_min_priority_queue: FAILED **");
            $finish;
        end
    end

    initial begin : receiver
        int unsigned mode;
        int unsigned run;
        int unsigned c;
        out_stall <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            mode = $urandom_range(9);
            run  = $urandom_range(40, 10);
            for (c = 0; c < run && !hold_request; c++) begin
                case (mode)
                    0, 1, 2: out_stall <= 1'b0;
                    3, 4, 5, 6: out_stall <= ($urandom_range(99) < 25);
                    7, 8: out_stall <= ($urandom_range(99) < 70);
                    default: out_stall <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int          i;
        int          n;
        int          block;
        int          block_len;
        int unsigned insert_pct;
        logic        cmd;

        sb        = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: serve when empty, extreme and equal keys, then a full queue.
        send_command(CMD_SERVE, t_key'($urandom()));
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_INSERT, 32'sh0000_0000);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, 32'sh0000_0001);
        for (i = 0; i < QUEUE_DEPTH - 6; i++)
            send_command(CMD_INSERT, 32'sh0000_0001);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_SERVE, t_key'($urandom()));
        send_command(CMD_SERVE, t_key'($urandom()));

        // Random blocks lean towards filling, draining or neither, so that both
        // the full and the empty queue are reached again and again.
        n     = 0;
        block = 0;
        while (n < RANDOM_ITEMS) begin
            block_len = $urandom_range(60, 20);
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            no_gaps = ($urandom_range(3) == 0);
            if (block == 3) begin
                // Keep offering beats while the receiver holds off.
                no_gaps      = 1'b1;
                hold_request = 1'b1;
            end
            for (i = 0; i < block_len; i++) begin
                cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_SERVE;
                send_command(cmd, pick_key());
            end
            n += block_len;
            block++;
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d commands and %0d result beats: %0d keys served,",
                 sb.commands_seen, sb.results_seen, sb.keys_served);
        $display("%0d serves on an empty queue, %0d inserts dropped at full, %0d mismatches.",
                 sb.empty_serves, sb.full_drops, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("** sorted_min_priority_queue: PASSED **");
        end else begin
            $display("** sorted_min_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_min_priority_queue.sv
bench/testbench.sv
